// ===== rtl/bte_pkg.sv =====
// Shared types, codes and lookup functions for the broadcast text encoder.
// No dependencies; every other rtl file refers to this package by scoped name.
package bte_pkg;

   localparam logic [6:0] ESC_SEPTET = 7'h1b;
   localparam logic [6:0] CR_SEPTET  = 7'h0d;
   localparam logic [7:0] NO_CODE    = 8'hff;
   localparam int unsigned QUEUE_DEPTH = 2;

   typedef enum logic [1:0] {
      ST_OK     = 2'd0,
      ST_ALPHA  = 2'd1,
      ST_UTF8   = 2'd2,
      ST_SCHEME = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      MODE_GSM7 = 2'd0,
      MODE_UCS2 = 2'd1,
      MODE_BAD  = 2'd2
   } mode_type;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       msg_end;
   } req_payload_type;

   typedef struct packed {
      logic [7:0] out_byte;
      status_type status;
      logic       out_last;
   } rsp_payload_type;

   // one accepted byte's worth of results, octets[0] goes out first
   typedef struct packed {
      logic [1:0]      count;
      logic [2:0][7:0] octets;
      status_type      status;
      logic            last;
   } enc_cmd_type;

   function automatic mode_type select_mode(input logic [7:0] dcs);
      mode_type m;
      m = MODE_BAD;
      case (dcs[7:4])
         4'h0: m = MODE_GSM7;
         4'h4, 4'h5: begin
            case (dcs[3:2])
               2'd0: m = MODE_GSM7;
               2'd2: m = MODE_UCS2;
               default: m = MODE_BAD;
            endcase
         end
         4'hf: m = dcs[2] ? MODE_BAD : MODE_GSM7;
         default: m = MODE_BAD;
      endcase
      return m;
   endfunction

   // septet code, bit 7 set for extension table, NO_CODE if unmappable
   function automatic logic [7:0] gsm7_lookup(input logic [7:0] c);
      logic [7:0] r;
      case (c) inside
         8'h40: r = 8'h00;
         8'h24: r = 8'h02;
         8'h0a: r = 8'h0a;
         8'h5f: r = 8'h11;
         8'h5e: r = 8'h94;
         8'h7b: r = 8'ha8;
         8'h7d: r = 8'ha9;
         8'h5c: r = 8'haf;
         8'h5b: r = 8'hbc;
         8'h7e: r = 8'hbd;
         8'h5d: r = 8'hbe;
         8'h7c: r = 8'hc0;
         [8'h20:8'h3f], [8'h41:8'h5a], [8'h61:8'h7a]: r = c;
         default: r = NO_CODE;
      endcase
      return r;
   endfunction

endpackage

// ===== rtl/bte_front.sv =====
// Front end: scheme register, character classification, septet packing and
// UTF-8 assembly, at most one result record per byte. Depends on bte_pkg.
module bte_front (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  bte_pkg::req_payload_type req_payload,
   input  logic                     csr_wr_en,
   input  logic [7:0]               csr_wr_data,
   input  logic                     q_full,
   output logic                     push,
   output bte_pkg::enc_cmd_type     push_cmd
);

   logic [7:0]  scheme_ff;
   logic [6:0]  res_ff, res_in;
   logic [2:0]  cnt_ff, cnt_in;
   logic [15:0] accum_ff, accum_in;
   logic [1:0]  pend_ff, pend_in;
   logic        disc_ff, disc_in;

   logic              accept;
   logic              msg_end;
   logic [7:0]        in_byte;
   bte_pkg::mode_type mode;
   logic [7:0]        code;
   logic [13:0]       pair;
   logic [4:0]        add_bits;
   logic [4:0]        tot;
   logic [1:0]        nfull;
   logic [2:0]        rem;
   logic [2:0][7:0]   packed_v;
   logic [15:0]       code16;
   logic [1:0]        pend_v;
   logic              bad_lead;
   logic                 fail_hit;
   bte_pkg::status_type  fail_status;

   assign req_stall = q_full;
   assign accept    = req_valid && !q_full;
   assign msg_end   = req_payload.msg_end;
   assign in_byte   = req_payload.in_byte;
   assign mode      = bte_pkg::select_mode(scheme_ff);
   assign code      = bte_pkg::gsm7_lookup(in_byte);

   // GSM-7 packing
   always_comb begin
      if (code[7]) begin
         pair     = {code[6:0], bte_pkg::ESC_SEPTET};
         add_bits = 5'd14;
      end else begin
         pair     = {7'b0, code[6:0]};
         add_bits = 5'd7;
      end
      packed_v = {17'b0, res_ff} | ({10'b0, pair} << cnt_ff);
      tot      = {2'b0, cnt_ff} + add_bits;
      nfull    = tot[4:3];
      rem      = tot[2:0];
      if (msg_end && rem == 3'd1) begin
         packed_v[nfull] = packed_v[nfull] | {bte_pkg::CR_SEPTET, 1'b0};
      end
   end

   // UTF-8 assembly
   always_comb begin
      bad_lead = 1'b0;
      code16   = accum_ff;
      pend_v   = pend_ff;
      if (pend_ff == 2'd0) begin
         if (in_byte[7] == 1'b0) begin
            code16 = {8'b0, in_byte};
         end else if ((in_byte & 8'he0) == 8'hc0) begin
            code16 = {11'b0, in_byte[4:0]};
            pend_v = 2'd1;
         end else if ((in_byte & 8'hf0) == 8'he0) begin
            code16 = {12'b0, in_byte[3:0]};
            pend_v = 2'd2;
         end else begin
            bad_lead = 1'b1;
         end
      end else begin
         code16 = {accum_ff[9:0], in_byte[5:0]};
         pend_v = pend_ff - 2'd1;
      end
   end

   always_comb begin
      res_in      = res_ff;
      cnt_in      = cnt_ff;
      accum_in    = accum_ff;
      pend_in     = pend_ff;
      disc_in     = disc_ff;
      push        = 1'b0;
      push_cmd    = '0;
      fail_hit    = 1'b0;
      fail_status = bte_pkg::ST_OK;
      if (accept) begin
         if (disc_ff) begin
            if (msg_end) begin
               disc_in = 1'b0;
            end
         end else if (mode == bte_pkg::MODE_BAD) begin
            fail_hit    = 1'b1;
            fail_status = bte_pkg::ST_SCHEME;
         end else if (mode == bte_pkg::MODE_GSM7) begin
            if (code == bte_pkg::NO_CODE) begin
               fail_hit    = 1'b1;
               fail_status = bte_pkg::ST_ALPHA;
            end else begin
               push_cmd.octets = packed_v;
               push_cmd.count  = nfull + {1'b0, (msg_end && rem != 3'd0)};
               push_cmd.status = bte_pkg::ST_OK;
               push_cmd.last   = msg_end;
               push            = (push_cmd.count != 2'd0);
               if (msg_end) begin
                  res_in   = '0;
                  cnt_in   = '0;
                  accum_in = '0;
                  pend_in  = '0;
               end else begin
                  res_in = packed_v[nfull][6:0];
                  cnt_in = rem;
               end
            end
         end else begin
            if (bad_lead || (pend_v != 2'd0 && msg_end)) begin
               fail_hit    = 1'b1;
               fail_status = bte_pkg::ST_UTF8;
            end else if (pend_v != 2'd0) begin
               accum_in = code16;
               pend_in  = pend_v;
            end else begin
               push               = 1'b1;
               push_cmd.count     = 2'd2;
               push_cmd.octets[0] = code16[15:8];
               push_cmd.octets[1] = code16[7:0];
               push_cmd.status    = bte_pkg::ST_OK;
               push_cmd.last      = msg_end;
               accum_in           = '0;
               pend_in            = '0;
               if (msg_end) begin
                  res_in = '0;
                  cnt_in = '0;
               end
            end
         end
      end
      if (fail_hit) begin
         res_in          = '0;
         cnt_in          = '0;
         accum_in        = '0;
         pend_in         = '0;
         disc_in         = !msg_end;
         push            = 1'b1;
         push_cmd        = '0;
         push_cmd.count  = 2'd1;
         push_cmd.status = fail_status;
         push_cmd.last   = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scheme_ff <= '0;
         res_ff    <= '0;
         cnt_ff    <= '0;
         accum_ff  <= '0;
         pend_ff   <= '0;
         disc_ff   <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            scheme_ff <= csr_wr_data;
         end
         res_ff   <= res_in;
         cnt_ff   <= cnt_in;
         accum_ff <= accum_in;
         pend_ff  <= pend_in;
         disc_ff  <= disc_in;
      end
   end

endmodule

// ===== rtl/bte_queue.sv =====
// Two-entry record queue between front and back end.
// Depends on bte_pkg for the record type and depth.
module bte_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  bte_pkg::enc_cmd_type push_cmd,
   input  logic                 pop,
   output logic                 full,
   output logic                 not_empty,
   output bte_pkg::enc_cmd_type head
);

   localparam int unsigned PtrW = $clog2(bte_pkg::QUEUE_DEPTH);
   localparam int unsigned CntW = $clog2(bte_pkg::QUEUE_DEPTH + 1);

   bte_pkg::enc_cmd_type entry_ff [bte_pkg::QUEUE_DEPTH];
   logic [PtrW-1:0] wr_ff, wr_in;
   logic [PtrW-1:0] rd_ff, rd_in;
   logic [CntW-1:0] count_ff, count_in;

   assign full      = (count_ff == CntW'(bte_pkg::QUEUE_DEPTH));
   assign not_empty = (count_ff != '0);
   assign head      = entry_ff[rd_ff];

   always_comb begin
      wr_in    = wr_ff;
      rd_in    = rd_ff;
      count_in = count_ff;
      if (push) begin
         wr_in = (wr_ff == PtrW'(bte_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ff + 1'b1;
      end
      if (pop) begin
         rd_in = (rd_ff == PtrW'(bte_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ff] <= push_cmd;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(push && full && !pop))
      else $error("queue push while full");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> not_empty)
      else $error("queue pop while empty");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CntW'(bte_pkg::QUEUE_DEPTH))
      else $error("queue count out of range");

endmodule

// ===== rtl/bte_back.sv =====
// Back end: takes result records from the queue and sends them one beat
// at a time on the result channel. Depends on bte_pkg.
module bte_back (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     q_not_empty,
   input  bte_pkg::enc_cmd_type     head,
   output logic                     pop,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output bte_pkg::rsp_payload_type rsp_payload
);

   bte_pkg::enc_cmd_type cur_ff, cur_in;
   logic                 valid_ff, valid_in;
   logic [1:0]           idx_ff, idx_in;
   logic                 beat_done;
   logic                 final_beat;

   assign beat_done  = valid_ff && !rsp_stall;
   assign final_beat = (idx_ff == cur_ff.count - 2'd1);
   assign pop        = q_not_empty && (!valid_ff || (beat_done && final_beat));

   assign rsp_valid            = valid_ff;
   assign rsp_payload.out_byte = cur_ff.octets[idx_ff];
   assign rsp_payload.status   = cur_ff.status;
   assign rsp_payload.out_last = cur_ff.last && final_beat;

   always_comb begin
      cur_in   = cur_ff;
      valid_in = valid_ff;
      idx_in   = idx_ff;
      if (pop) begin
         cur_in   = head;
         valid_in = 1'b1;
         idx_in   = '0;
      end else if (beat_done && final_beat) begin
         valid_in = 1'b0;
      end else if (beat_done) begin
         idx_in = idx_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= '0;
      end else begin
         valid_ff <= valid_in;
         idx_ff   <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
   end

   a_idx_in_record: assert property (@(posedge clock) disable iff (reset)
      valid_ff |-> (cur_ff.count != 2'd0 && idx_ff < cur_ff.count))
      else $error("beat index outside record");

   a_error_is_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_payload.status != bte_pkg::ST_OK) |->
         (rsp_payload.out_last && rsp_payload.out_byte == 8'h00))
      else $error("error beat not final or not zero");

   a_advance_on_beat: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && rsp_stall) |=> (valid_ff && $stable(idx_ff)))
      else $error("beat index moved while stalled");

endmodule

// ===== rtl/broadcast_text_encoder.sv =====
// Broadcast text encoder top level: front end, record queue, back end.
// Depends on bte_pkg, bte_front, bte_queue and bte_back.
//
// Message bytes enter on req_* with msg_end on the final byte; encoded
// octets leave on rsp_* with out_last on the final result of a message.
// csr_wr_en/csr_wr_data load the coding scheme byte (GSM-7, UCS-2 or
// unsupported); write it only between messages.
// Records are registered in the queue, then in the back end, before output.
// Throughput: the output, one octet per cycle while rsp_stall is low, sets
// the rate; bytes yielding at most one octet flow at one byte per cycle, and
// a byte yielding k octets (up to three) holds the output for all k. The
// front end packs and classifies a byte in its accept cycle and queues at
// most one record; a two-entry queue lets the front keep accepting while
// the back end waits on rsp_stall. req_stall rises when the queue is full.
// Errors give one zero octet with an error status and out_last; the rest
// of that message is dropped without results.
// Reset (synchronous) clears the scheme to 0, all packing and UTF-8 state
// and the queue; no clearing pass is needed.
module broadcast_text_encoder (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  bte_pkg::req_payload_type req_payload,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output bte_pkg::rsp_payload_type rsp_payload,
   input  logic                     csr_wr_en,
   input  logic [7:0]               csr_wr_data
);

   logic                 q_full;
   logic                 q_not_empty;
   logic                 push;
   logic                 pop;
   bte_pkg::enc_cmd_type push_cmd;
   bte_pkg::enc_cmd_type head;

   bte_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .q_full      (q_full),
      .push        (push),
      .push_cmd    (push_cmd)
   );

   bte_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_cmd  (push_cmd),
      .pop       (pop),
      .full      (q_full),
      .not_empty (q_not_empty),
      .head      (head)
   );

   bte_back u_back (
      .clock       (clock),
      .reset       (reset),
      .q_not_empty (q_not_empty),
      .head        (head),
      .pop         (pop),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

endmodule

// ===== tb/tb_top.sv =====
// Self-checking testbench for broadcast_text_encoder: GSM-7 packing, UCS-2 and error results.
// Needs bte_pkg and the encoder RTL. A clocked driver and monitor share a predictor that
// tracks the coding scheme, septet packing and UTF-8 assembly to build the expected octets.
module tb_top;

   localparam int CYCLE_LIMIT = 600000;

   logic                     clock;
   logic                     reset = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_stall;
   bte_pkg::req_payload_type req_payload = '0;
   logic                     rsp_valid;
   logic                     rsp_stall = 1'b0;
   bte_pkg::rsp_payload_type rsp_payload;
   logic                     csr_wr_en = 1'b0;
   logic [7:0]               csr_wr_data = 8'h00;

   bte_pkg::req_payload_type pending_bytes[$];
   bte_pkg::rsp_payload_type want_octets[$];
   bte_pkg::rsp_payload_type want_head;

   // predictor state
   logic [7:0]  cur_scheme = 8'h00;
   logic [6:0]  pk_bits = '0;
   int          pk_count = 0;
   logic [15:0] utf_code = '0;
   int          utf_left = 0;
   bit          drop_rest = 1'b0;

   int errors = 0;
   int queued = 0;
   int rsp_seen = 0;
   int cycle_count = 0;
   int send_gap = 0;
   int tx_calm = 0;
   int rx_hold = 0;
   int rx_calm = 0;
   bit long_hold_done = 1'b0;

   broadcast_text_encoder u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_payload(req_payload),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_payload(rsp_payload),
      .csr_wr_en  (csr_wr_en),
      .csr_wr_data(csr_wr_data)
   );

   always begin
      clock = 1'b0;
      #6;
      clock = 1'b1;
      #6;
   end

   function automatic bte_pkg::mode_type scheme_mode(input logic [7:0] dcs);
      if (dcs[7:4] == 4'h0) return bte_pkg::MODE_GSM7;
      if (dcs[7:5] == 3'b010) begin
         if (dcs[3:2] == 2'b00) return bte_pkg::MODE_GSM7;
         if (dcs[3:2] == 2'b10) return bte_pkg::MODE_UCS2;
         return bte_pkg::MODE_BAD;
      end
      if (dcs[7:4] == 4'hf && !dcs[2]) return bte_pkg::MODE_GSM7;
      return bte_pkg::MODE_BAD;
   endfunction

   // default alphabet septet; ext set for characters behind the escape
   function automatic bit septet_of(input logic [7:0] c, output logic [6:0] code,
                                    output bit ext);
      ext  = 1'b1;
      code = 7'h00;
      case (c)
         8'h5e: code = 7'h14;
         8'h7b: code = 7'h28;
         8'h7d: code = 7'h29;
         8'h5c: code = 7'h2f;
         8'h5b: code = 7'h3c;
         8'h7e: code = 7'h3d;
         8'h5d: code = 7'h3e;
         8'h7c: code = 7'h40;
         default: ext = 1'b0;
      endcase
      if (ext) return 1'b1;
      if (c == 8'h40) code = 7'h00;
      else if (c == 8'h24) code = 7'h02;
      else if (c == 8'h0a) code = 7'h0a;
      else if (c == 8'h5f) code = 7'h11;
      else if ((c >= 8'h20 && c <= 8'h3f) || (c >= 8'h41 && c <= 8'h5a) ||
               (c >= 8'h61 && c <= 8'h7a)) code = c[6:0];
      else return 1'b0;
      return 1'b1;
   endfunction

   function automatic void want_beat(input logic [7:0] ob, input bte_pkg::status_type st,
                                     input bit lb);
      bte_pkg::rsp_payload_type w;
      w.out_byte = ob;
      w.status   = st;
      w.out_last = lb;
      want_octets.insert(want_octets.size(), w);
   endfunction

   task automatic expect_error(input bte_pkg::status_type st, input bit at_end);
      pk_bits   = '0;
      pk_count  = 0;
      utf_code  = '0;
      utf_left  = 0;
      drop_rest = !at_end;
      want_beat(8'h00, st, 1'b1);
   endtask

   task automatic predict_octets(input bte_pkg::req_payload_type beat);
      bte_pkg::mode_type m;
      logic [6:0]        code;
      bit                ext;
      logic [31:0]       acc;
      int                cnt;
      logic [7:0]        octs[$];
      logic [7:0]        b;
      b = beat.in_byte;
      if (drop_rest) begin
         if (beat.msg_end) drop_rest = 1'b0;
         return;
      end
      m = scheme_mode(cur_scheme);
      if (m == bte_pkg::MODE_BAD) begin
         expect_error(bte_pkg::ST_SCHEME, beat.msg_end);
         return;
      end
      if (m == bte_pkg::MODE_GSM7) begin
         if (!septet_of(b, code, ext)) begin
            expect_error(bte_pkg::ST_ALPHA, beat.msg_end);
            return;
         end
         acc = {25'd0, pk_bits};
         cnt = pk_count;
         if (ext) begin
            acc |= {25'd0, bte_pkg::ESC_SEPTET} << cnt;
            cnt += 7;
         end
         acc |= {25'd0, code} << cnt;
         cnt += 7;
         while (cnt >= 8) begin
            octs.insert(octs.size(), acc[7:0]);
            acc = acc >> 8;
            cnt -= 8;
         end
         if (beat.msg_end) begin
            if (cnt == 1) acc |= {25'd0, bte_pkg::CR_SEPTET} << 1;
            if (cnt > 0) octs.insert(octs.size(), acc[7:0]);
            pk_bits  = '0;
            pk_count = 0;
            utf_code = '0;
            utf_left = 0;
         end else begin
            pk_bits  = acc[6:0];
            pk_count = cnt;
         end
         foreach (octs[i])
            want_beat(octs[i], bte_pkg::ST_OK, beat.msg_end && (i == octs.size() - 1));
         return;
      end
      // UCS-2
      if (utf_left == 0) begin
         if (!b[7]) begin
            utf_code = {8'h00, b};
         end else if (b[7:5] == 3'b110) begin
            utf_code = {11'd0, b[4:0]};
            utf_left = 1;
         end else if (b[7:4] == 4'b1110) begin
            utf_code = {12'd0, b[3:0]};
            utf_left = 2;
         end else begin
            expect_error(bte_pkg::ST_UTF8, beat.msg_end);
            return;
         end
      end else begin
         utf_code = {utf_code[9:0], b[5:0]};
         utf_left--;
      end
      if (utf_left != 0) begin
         if (beat.msg_end) expect_error(bte_pkg::ST_UTF8, 1'b1);
         return;
      end
      want_beat(utf_code[15:8], bte_pkg::ST_OK, 1'b0);
      want_beat(utf_code[7:0], bte_pkg::ST_OK, beat.msg_end);
      utf_code = '0;
      if (beat.msg_end) begin
         pk_bits  = '0;
         pk_count = 0;
         utf_left = 0;
      end
   endtask

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 88) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) predict_octets(req_payload);
         if (!req_valid || !req_stall) begin
            if (send_gap != 0) begin
               send_gap--;
               req_valid <= 1'b0;
            end else if (pending_bytes.size() != 0) begin
               req_payload <= pending_bytes.pop_front();
               req_valid   <= 1'b1;
               if (tx_calm != 0) begin
                  tx_calm--;
               end else if ($urandom_range(0, 39) == 0) begin
                  tx_calm = $urandom_range(20, 60);
               end else begin
                  send_gap = pick_gap();
               end
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            rsp_seen++;
            if (want_octets.size() == 0) begin
               errors++;
               $display("%0t: unexpected beat, expected none, got %h/%0d/%b", $time,
                        rsp_payload.out_byte, rsp_payload.status, rsp_payload.out_last);
            end else begin
               want_head = want_octets.pop_front();
               if (rsp_payload.out_byte !== want_head.out_byte ||
                   rsp_payload.status !== want_head.status ||
                   rsp_payload.out_last !== want_head.out_last) begin
                  errors++;
                  $display("%0t: mismatch, expected %h/%0d/%b, got %h/%0d/%b", $time,
                           want_head.out_byte, want_head.status, want_head.out_last,
                           rsp_payload.out_byte, rsp_payload.status, rsp_payload.out_last);
               end
            end
         end
         if (rx_hold != 0) begin
            rx_hold--;
            rsp_stall <= 1'b1;
         end else if (!long_hold_done && rsp_seen >= 60) begin
            // long back-pressure so the encoder fills and stalls its input
            long_hold_done = 1'b1;
            rx_hold = 150;
            rsp_stall <= 1'b1;
         end else if (rx_calm != 0) begin
            rx_calm--;
            rsp_stall <= 1'b0;
         end else if ($urandom_range(0, 39) == 0) begin
            rx_calm = $urandom_range(20, 60);
            rsp_stall <= 1'b0;
         end else begin
            rx_hold = pick_gap();
            if (rx_hold != 0) begin
               rx_hold--;
               rsp_stall <= 1'b1;
            end else begin
               rsp_stall <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("broadcast_text_encoder regression: fail");
         $finish;
      end
   end

   task automatic send_byte(input logic [7:0] b, input bit last_one);
      bte_pkg::req_payload_type p;
      p.in_byte = b;
      p.msg_end = last_one;
      pending_bytes.insert(pending_bytes.size(), p);
      queued++;
   endtask

   task automatic wait_idle();
      while (pending_bytes.size() != 0 || req_valid || want_octets.size() != 0)
         @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_scheme(input logic [7:0] v);
      wait_idle();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= v;
      @(posedge clock);
      csr_wr_en  <= 1'b0;
      cur_scheme = v;
   endtask

   function automatic logic [7:0] pick_scheme();
      case ($urandom_range(0, 9))
         0: return {4'h0, 4'($urandom_range(0, 15))};
         1: return {3'b010, 1'($urandom_range(0, 1)), 2'b00, 2'($urandom_range(0, 3))};
         2: return {4'hf, 1'($urandom_range(0, 1)), 1'b0, 2'($urandom_range(0, 3))};
         3, 4, 5: return {3'b010, 1'($urandom_range(0, 1)), 2'b10, 2'($urandom_range(0, 3))};
         6: return 8'hff;
         7, 8: return 8'($urandom_range(0, 255));
         default: return 8'h00;
      endcase
   endfunction

   task automatic queue_message();
      bte_pkg::mode_type m;
      int                len;
      int                kind;
      logic [7:0]        c;
      logic [6:0]        code;
      bit                ext;
      logic [7:0]        seq[$];
      logic [7:0]        ext_chars[8];
      ext_chars = '{8'h5e, 8'h7b, 8'h7d, 8'h5c, 8'h5b, 8'h7e, 8'h5d, 8'h7c};
      m = scheme_mode(cur_scheme);
      if (m == bte_pkg::MODE_GSM7) begin
         len = $urandom_range(1, 10);
         for (int i = 0; i < len; i++) begin
            if ($urandom_range(0, 11) == 0) begin
               c = 8'($urandom_range(0, 255));
            end else if ($urandom_range(0, 4) == 0) begin
               c = ext_chars[$urandom_range(0, 7)];
            end else begin
               do c = 8'($urandom_range(0, 127)); while (!septet_of(c, code, ext));
            end
            seq.insert(seq.size(), c);
         end
      end else if (m == bte_pkg::MODE_UCS2) begin
         len = $urandom_range(1, 6);
         kind = 0;
         for (int i = 0; i < len; i++) begin
            kind = $urandom_range(0, 3);
            if ($urandom_range(0, 11) == 0) begin
               seq.insert(seq.size(), 8'($urandom_range(0, 255)));
               kind = 0;
            end else if (kind == 0) begin
               seq.insert(seq.size(), 8'($urandom_range(0, 127)));
            end else if (kind == 1) begin
               seq.insert(seq.size(), {3'b110, 5'($urandom_range(0, 31))});
               seq.insert(seq.size(), {2'b10, 6'($urandom_range(0, 63))});
            end else begin
               seq.insert(seq.size(), {4'b1110, 4'($urandom_range(0, 15))});
               seq.insert(seq.size(), {2'b10, 6'($urandom_range(0, 63))});
               seq.insert(seq.size(), {2'b10, 6'($urandom_range(0, 63))});
            end
         end
         // cut the final sequence short now and then
         if (kind != 0 && $urandom_range(0, 7) == 0) void'(seq.pop_back());
      end else begin
         len = $urandom_range(1, 4);
         for (int i = 0; i < len; i++) seq.insert(seq.size(), 8'($urandom_range(0, 255)));
      end
      foreach (seq[i]) send_byte(seq[i], i == seq.size() - 1);
   endtask

   initial begin
      int phase_base;
      int target;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // GSM-7 at the reset scheme: escape, CR fill, unmappable and discard
      send_byte(8'h40, 0); send_byte(8'h24, 0); send_byte(8'h7c, 0);
      send_byte(8'h3f, 0); send_byte(8'h5a, 0); send_byte(8'h61, 1);
      send_byte(8'h20, 1);
      send_byte(8'h0a, 0); send_byte(8'h80, 0); send_byte(8'h41, 0); send_byte(8'h7a, 1);
      send_byte(8'hff, 1);
      send_byte(8'h00, 1);

      // UCS-2: one, two and three byte forms, bad lead, truncation
      write_scheme(8'h48);
      send_byte(8'h00, 1);
      send_byte(8'h7f, 0); send_byte(8'hc3, 0); send_byte(8'ha9, 0);
      send_byte(8'he2, 0); send_byte(8'h82, 0); send_byte(8'hac, 1);
      send_byte(8'h80, 0); send_byte(8'h41, 1);
      send_byte(8'hf0, 1);
      send_byte(8'hef, 0); send_byte(8'hbf, 1);

      write_scheme(8'hff);
      send_byte(8'h41, 0); send_byte(8'h42, 1);

      for (int p = 0; p < 9; p++) begin
         write_scheme(p == 0 ? 8'h00 : pick_scheme());
         target = (scheme_mode(cur_scheme) == bte_pkg::MODE_BAD) ? 15 : 55;
         phase_base = queued;
         while (queued < phase_base + target) queue_message();
      end

      wait_idle();
      repeat (20) @(posedge clock);
      if (errors == 0)
         $display("broadcast_text_encoder regression: pass");
      else
         $display("broadcast_text_encoder regression: fail");
      $finish;
   end

endmodule
